// ----- hw/rtl/bba_pkg.sv -----
package bba_pkg;

  // Heap geometry
  localparam int unsigned TopLevel    = 16;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned MinLevel    = 5;

  localparam int unsigned SpanLevels = TopLevel - MinLevel;
  localparam int unsigned UnitCount  = 1 << SpanLevels;
  localparam int unsigned TreeCount  = 1 << (SpanLevels + 1);
  localparam int unsigned RowBits    = 32;
  localparam int unsigned RowCount   = TreeCount / RowBits;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned IdW    = $clog2(TreeCount);
  localparam int unsigned UnitW  = $clog2(UnitCount);
  localparam int unsigned RowW   = $clog2(RowCount);
  localparam int unsigned BitW   = $clog2(RowBits);
  localparam int unsigned LvlW   = 5;
  localparam int unsigned TotalW = AddrW + 1;

  localparam logic [TotalW-1:0] HeapSize = TotalW'(1) << TopLevel;

  // Item codes
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusNoSpace = 2'd1;
  localparam logic [1:0] StatusBadFree = 2'd2;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] request_bytes;
    logic [AddrW-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] granted_address;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic           found;
    logic [IdW-1:0] id;
  } scan_res_t;

  // Smallest level whose block holds total bytes, never below the minimum.
  function automatic logic [LvlW-1:0] need_level(input logic [TotalW-1:0] total);
    logic [LvlW-1:0] need;
    need = LvlW'(TopLevel);
    for (int l = TopLevel - 1; l >= MinLevel; l--) begin
      if (total <= (TotalW'(1) << l)) begin
        need = LvlW'(l);
      end
    end
    return need;
  endfunction

  // First node id of a level.
  function automatic logic [IdW-1:0] level_first(input logic [LvlW-1:0] lvl);
    return IdW'(1) << (LvlW'(TopLevel) - lvl);
  endfunction

  // Last node id of a level.
  function automatic logic [IdW-1:0] level_last(input logic [LvlW-1:0] lvl);
    logic [IdW:0] span;
    span = (IdW + 1)'(1) << (LvlW'(TopLevel) - lvl);
    return IdW'((span << 1) - (IdW + 1)'(1));
  endfunction

endpackage

// ----- hw/rtl/bba_row_scan.sv -----
module bba_row_scan import bba_pkg::*; (
  input  logic [RowW-1:0]    row_i,
  input  logic [RowBits-1:0] data_i,
  input  logic [LvlW-1:0]    lvl_i,
  output scan_res_t          res_o
);

  logic [IdW-1:0] lo;
  logic [IdW-1:0] hi;

  assign lo = level_first(lvl_i);
  assign hi = level_last(lvl_i);

  // Lowest free node of the level within this row.
  always_comb begin
    logic [IdW-1:0] id;
    res_o = '0;
    for (int b = RowBits - 1; b >= 0; b--) begin
      id = {row_i, BitW'(b)};
      if (data_i[b] && id >= lo && id <= hi) begin
        res_o.found = 1'b1;
        res_o.id    = id;
      end
    end
  end

endmodule

// ----- hw/rtl/buddy_block_allocator.sv -----
// Sequencing: allocate reads each free-map row of a level in turn, climbing levels until a free
//   block is found, then splits down level by level; free checks the held level, then merges each free buddy.
// Throughput: one item at a time; a new item is taken only once the read-modify-write walk over the
//   free-map memory (one row read, one row write) for the last one is done.
// Reset: asynchronous, active low; afterwards a clearing pass over every unit zeroes the
//   held-level memory and loads the free map with only the whole heap free.
module buddy_block_allocator import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_USE, S_SPLIT_RD, S_SPLIT_WR, S_HOLD_WR,
    S_FREE_RD, S_FREE_CHK, S_MERGE_RD, S_MERGE_USE, S_SET_RD, S_SET_WR, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [UnitW-1:0] clr_q, clr_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [LvlW-1:0]  need_q, need_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [AddrW-1:0] base_q, base_d;
  out_item_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  // Free map: one bit per tree node, RowBits nodes a row
  logic [RowBits-1:0] fmap_mem [RowCount];
  logic [RowBits-1:0] fm_rdata_q;
  logic               fm_re, fm_we;
  logic [RowW-1:0]    fm_raddr, fm_waddr;
  logic [RowBits-1:0] fm_wdata;

  // Held level of the allocated block at each minimum-size unit
  logic [LvlW-1:0]  held_mem [UnitCount];
  logic [LvlW-1:0]  hl_rdata_q;
  logic             hl_re, hl_we;
  logic [UnitW-1:0] hl_raddr, hl_waddr;
  logic [LvlW-1:0]  hl_wdata;

  scan_res_t scan;

  bba_row_scan u_row_scan (
    .row_i  (row_q),
    .data_i (fm_rdata_q),
    .lvl_i  (lvl_q),
    .res_o  (scan)
  );

  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      fmap_mem[fm_waddr] <= fm_wdata;
    end
    if (fm_re) begin
      fm_rdata_q <= fmap_mem[fm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hl_we) begin
      held_mem[hl_waddr] <= hl_wdata;
    end
    if (hl_re) begin
      hl_rdata_q <= held_mem[hl_raddr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    logic [TotalW-1:0] total;
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  idx;
    logic [TotalW-1:0] lmask;
    logic [IdW-1:0]    sib;
    logic [LvlW-1:0]   hl;
    logic [LvlW-1:0]   nlvl;
    logic [IdW-1:0]    first_id;
    logic [IdW-1:0]    last_id;

    state_d     = state_q;
    clr_d       = clr_q;
    lvl_d       = lvl_q;
    need_d      = need_q;
    row_d       = row_q;
    id_d        = id_q;
    base_d      = base_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    fm_re    = 1'b0;
    fm_we    = 1'b0;
    fm_raddr = '0;
    fm_waddr = '0;
    fm_wdata = '0;
    hl_re    = 1'b0;
    hl_we    = 1'b0;
    hl_raddr = '0;
    hl_waddr = '0;
    hl_wdata = '0;

    total    = TotalW'(in_item_i.request_bytes) + TotalW'(HeaderBytes);
    base     = in_item_i.block_address - AddrW'(HeaderBytes);
    idx      = '0;
    lmask    = '0;
    sib      = '0;
    hl       = hl_rdata_q;
    nlvl     = lvl_q + LvlW'(1);
    first_id = '0;
    last_id  = '0;

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        // Zero held levels; seed the free map with only the root free
        hl_we    = 1'b1;
        hl_waddr = clr_q;
        hl_wdata = '0;
        if (clr_q < UnitW'(RowCount)) begin
          fm_we    = 1'b1;
          fm_waddr = clr_q[RowW-1:0];
          fm_wdata = (clr_q == '0) ? RowBits'(2) : '0;
        end
        clr_d = clr_q + UnitW'(1);
        if (clr_q == UnitW'(UnitCount - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_d.granted_address = '0;
          if (in_item_i.mode == ModeAlloc) begin
            if (in_item_i.request_bytes == '0 || total > HeapSize) begin
              res_d.status = StatusNoSpace;
              state_d      = S_DONE;
            end else begin
              first_id = level_first(need_level(total));
              need_d   = need_level(total);
              lvl_d    = need_level(total);
              row_d    = first_id[IdW-1:BitW];
              state_d  = S_SCAN_RD;
            end
          end else begin
            if (in_item_i.block_address < AddrW'(HeaderBytes) ||
                base[MinLevel-1:0] != '0) begin
              res_d.status = StatusBadFree;
              state_d      = S_DONE;
            end else begin
              base_d  = base;
              state_d = S_FREE_RD;
            end
          end
        end
      end

      S_SCAN_RD: begin
        fm_re    = 1'b1;
        fm_raddr = row_q;
        state_d  = S_SCAN_USE;
      end

      S_SCAN_USE: begin
        last_id  = level_last(lvl_q);
        first_id = level_first(nlvl);
        if (scan.found) begin
          // Take the block, then split down if it is larger than needed
          fm_we    = 1'b1;
          fm_waddr = row_q;
          fm_wdata = fm_rdata_q & ~(RowBits'(1) << scan.id[BitW-1:0]);
          id_d     = scan.id;
          state_d  = (lvl_q > need_q) ? S_SPLIT_RD : S_HOLD_WR;
        end else if (row_q != last_id[IdW-1:BitW]) begin
          row_d   = row_q + RowW'(1);
          state_d = S_SCAN_RD;
        end else if (lvl_q == LvlW'(TopLevel)) begin
          res_d.status = StatusNoSpace;
          state_d      = S_DONE;
        end else begin
          lvl_d   = nlvl;
          row_d   = first_id[IdW-1:BitW];
          state_d = S_SCAN_RD;
        end
      end

      S_SPLIT_RD: begin
        // Step to the lower half; fetch the row of the upper half
        id_d     = {id_q[IdW-2:0], 1'b0};
        sib      = {id_q[IdW-2:0], 1'b1};
        lvl_d    = lvl_q - LvlW'(1);
        fm_re    = 1'b1;
        fm_raddr = sib[IdW-1:BitW];
        state_d  = S_SPLIT_WR;
      end

      S_SPLIT_WR: begin
        sib      = id_q | IdW'(1);
        fm_we    = 1'b1;
        fm_waddr = sib[IdW-1:BitW];
        fm_wdata = fm_rdata_q | (RowBits'(1) << sib[BitW-1:0]);
        state_d  = (lvl_q > need_q) ? S_SPLIT_RD : S_HOLD_WR;
      end

      S_HOLD_WR: begin
        idx      = AddrW'(id_q - level_first(lvl_q)) << lvl_q;
        hl_we    = 1'b1;
        hl_waddr = idx[AddrW-1:MinLevel];
        hl_wdata = need_q;
        res_d.granted_address = idx + AddrW'(HeaderBytes);
        res_d.status          = StatusDone;
        state_d  = S_DONE;
      end

      S_FREE_RD: begin
        hl_re    = 1'b1;
        hl_raddr = base_q[AddrW-1:MinLevel];
        state_d  = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        lmask = (TotalW'(1) << hl) - TotalW'(1);
        if (hl < LvlW'(MinLevel) || hl > LvlW'(TopLevel) ||
            (TotalW'(base_q) & lmask) != '0) begin
          res_d.status = StatusBadFree;
          state_d      = S_DONE;
        end else begin
          hl_we    = 1'b1;
          hl_waddr = base_q[AddrW-1:MinLevel];
          hl_wdata = '0;
          lvl_d    = hl;
          id_d     = level_first(hl) + IdW'(base_q >> hl);
          state_d  = (hl == LvlW'(TopLevel)) ? S_SET_RD : S_MERGE_RD;
        end
      end

      S_MERGE_RD: begin
        sib      = id_q ^ IdW'(1);
        fm_re    = 1'b1;
        fm_raddr = sib[IdW-1:BitW];
        state_d  = S_MERGE_USE;
      end

      S_MERGE_USE: begin
        sib = id_q ^ IdW'(1);
        if (fm_rdata_q[sib[BitW-1:0]]) begin
          // Buddy free: absorb it and climb a level
          fm_we    = 1'b1;
          fm_waddr = sib[IdW-1:BitW];
          fm_wdata = fm_rdata_q & ~(RowBits'(1) << sib[BitW-1:0]);
          id_d     = id_q >> 1;
          lvl_d    = nlvl;
          state_d  = (nlvl == LvlW'(TopLevel)) ? S_SET_RD : S_MERGE_RD;
        end else begin
          state_d = S_SET_RD;
        end
      end

      S_SET_RD: begin
        fm_re    = 1'b1;
        fm_raddr = id_q[IdW-1:BitW];
        state_d  = S_SET_WR;
      end

      S_SET_WR: begin
        fm_we    = 1'b1;
        fm_waddr = id_q[IdW-1:BitW];
        fm_wdata = fm_rdata_q | (RowBits'(1) << id_q[BitW-1:0]);
        res_d.granted_address = '0;
        res_d.status          = StatusDone;
        state_d  = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    need_q     <= need_d;
    row_q      <= row_d;
    id_q       <= id_d;
    base_q     <= base_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  // The free map is never read and written in the same cycle
  a_fm_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fm_re && fm_we)) else $error("free map read and write overlap");

  // No item is taken during the clearing pass
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o) else $error("item taken while clearing");

  // A failed result, or one with an address below the header size, carries a zero address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != StatusDone ||
                    out_item_o.granted_address < AddrW'(HeaderBytes))
    |-> out_item_o.granted_address == '0) else $error("nonzero address on failure");

  // Scan level stays within the heap's levels
  a_scan_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN_USE |-> lvl_q >= LvlW'(MinLevel) && lvl_q <= LvlW'(TopLevel))
    else $error("scan level out of range");

  // A new result is loaded only from the done state
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE) else $error("stray result");

endmodule
